### hw/rtl/assert_macros.svh
// Assertion macros shared by the shell line lexer RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define SLL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lexer check failed");

// Check that an antecedent implies a consequent in the same cycle.
`define SLL_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lexer check failed");

// Check that an antecedent implies a consequent in the next cycle.
`define SLL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lexer check failed");

`else

`define SLL_ASSERT(name, prop)
`define SLL_ASSERT_IMPL(name, ante, cons)
`define SLL_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### hw/rtl/sll_pkg.sv
// Types, byte codes and limits of the shell line lexer.
// No dependencies; used by every lexer module.
`default_nettype none

package sll_pkg;

  // Saturation limit of the token counter, clipped to the 8-bit field
  localparam int unsigned MaxTokens = 255;
  localparam logic [7:0] CountLimit = (MaxTokens > 255) ? 8'd255 : 8'(MaxTokens);

  // Byte codes
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChPipe  = 8'h7C;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef enum logic [3:0] {
    ClBlank = 4'd0,
    ClPlain = 4'd1,
    ClDq    = 4'd2,
    ClSq    = 4'd3,
    ClInDq  = 4'd4,
    ClInSq  = 4'd5,
    ClLt    = 4'd6,
    ClGt    = 4'd7,
    ClPipe  = 4'd8
  } char_class_e;

  typedef enum logic [1:0] {
    QuoteNone = 2'd0,
    QuoteDq   = 2'd1,
    QuoteSq   = 2'd2
  } quote_e;

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindWord = 2'd1,
    KindLt   = 2'd2,
    KindGt   = 2'd3
  } token_kind_e;

  // Classifier verdict for one byte
  typedef struct packed {
    char_class_e cls;
    quote_e      quote_next;
  } cls_info_t;

  // Grouping verdict for one byte
  typedef struct packed {
    logic       in_token;
    logic       token_start;
    logic [7:0] token_number;
  } tok_info_t;

endpackage

`default_nettype wire

### hw/rtl/sll_classify.sv
// Byte classifier of the shell line lexer: class and next quote mode.
// Depends on sll_pkg.
`default_nettype none

module sll_classify
  import sll_pkg::*;
(
  input  var logic [7:0] ch_i,
  input  var quote_e     quote_i,
  output cls_info_t      info_o
);

  // Classify inside quotes first, then the plain byte set
  always_comb begin
    info_o.cls        = ClPlain;
    info_o.quote_next = QuoteNone;
    case (quote_i)
      QuoteDq: begin
        if (ch_i == ChDq) begin
          info_o.cls = ClDq;
        end else begin
          info_o.cls        = ClInDq;
          info_o.quote_next = QuoteDq;
        end
      end
      QuoteSq: begin
        if (ch_i == ChSq) begin
          info_o.cls = ClSq;
        end else begin
          info_o.cls        = ClInSq;
          info_o.quote_next = QuoteSq;
        end
      end
      default: begin
        if (ch_i inside {ChSpace, ChTab, ChNl}) begin
          info_o.cls = ClBlank;
        end else if (ch_i == ChLt) begin
          info_o.cls = ClLt;
        end else if (ch_i == ChGt) begin
          info_o.cls = ClGt;
        end else if (ch_i == ChPipe) begin
          info_o.cls = ClPipe;
        end else if (ch_i == ChDq) begin
          info_o.cls        = ClDq;
          info_o.quote_next = QuoteDq;
        end else if (ch_i == ChSq) begin
          info_o.cls        = ClSq;
          info_o.quote_next = QuoteSq;
        end else begin
          info_o.cls = ClPlain;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/sll_tracker.sv
// Token grouping state of the shell line lexer: quote mode, open token,
// redirect length and token counter. Depends on sll_pkg.
`default_nettype none

module sll_tracker
  import sll_pkg::*;
(
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      step_i,
  input  var logic      eol_i,
  input  var cls_info_t info_i,
  output quote_e        quote_o,
  output tok_info_t     tok_o
);

  quote_e      quote_q;
  token_kind_e kind_q, kind_d;
  logic        op_len_q, op_len_d;
  logic [7:0]  count_q, count_d;
  logic        start;
  logic        member;
  token_kind_e redir_kind;

  assign quote_o    = quote_q;
  assign redir_kind = (info_i.cls == ClLt) ? KindLt : KindGt;

  // Group the byte into the open token or start a new one
  always_comb begin
    kind_d   = kind_q;
    op_len_d = op_len_q;
    start    = 1'b0;
    member   = 1'b1;
    case (info_i.cls)
      ClBlank: begin
        member   = 1'b0;
        kind_d   = KindNone;
        op_len_d = 1'b0;
      end
      ClPipe: begin
        start    = 1'b1;
        kind_d   = KindNone;
        op_len_d = 1'b0;
      end
      ClLt, ClGt: begin
        if (kind_q == redir_kind && !op_len_q) begin
          op_len_d = 1'b1;
        end else begin
          start    = 1'b1;
          kind_d   = redir_kind;
          op_len_d = 1'b0;
        end
      end
      default: begin
        if (kind_q != KindWord) begin
          start  = 1'b1;
          kind_d = KindWord;
        end
        op_len_d = 1'b0;
      end
    endcase
  end

  // Count token starts, saturating at the limit
  assign count_d = (start && count_q < CountLimit) ? count_q + 8'd1 : count_q;

  assign tok_o.in_token     = member;
  assign tok_o.token_start  = start;
  assign tok_o.token_number = count_d;

  // Advance state per byte; clear it after the line's last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q  <= QuoteNone;
      kind_q   <= KindNone;
      op_len_q <= 1'b0;
      count_q  <= 8'd0;
    end else if (step_i) begin
      if (eol_i) begin
        quote_q  <= QuoteNone;
        kind_q   <= KindNone;
        op_len_q <= 1'b0;
        count_q  <= 8'd0;
      end else begin
        quote_q  <= info_i.quote_next;
        kind_q   <= kind_d;
        op_len_q <= op_len_d;
        count_q  <= count_d;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/shell_line_lexer.sv
// Top level of the shell line lexer: input register, classifier, token
// tracker and result register. Depends on sll_pkg, sll_classify, sll_tracker.
`default_nettype none

`include "assert_macros.svh"

// Shell line lexer. Takes one command-line byte per item and returns one
// result item per byte: its class, whether it belongs to a token, whether it
// starts one, and the running token number (saturating at the package limit).
// Throughput is one byte per cycle while the result is not stalled. A byte
// is held in the input register, and its result then in the result register.
// The rate is set by the quote and token state registers, which update once
// per byte as it moves from the input register to the result register. A byte
// with end_of_line set returns all state to reset after its result. Both
// channels use valid/stall; a stalled result holds the byte behind it in the
// input register, so the input stalls once both registers are full.
module shell_line_lexer
  import sll_pkg::*;
(
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       in_valid_i,
  output logic           in_stall_o,
  input  var logic [7:0] ch_i,
  input  var logic       end_of_line_i,
  output logic           out_valid_o,
  input  var logic       out_stall_i,
  output logic [3:0]     char_class_o,
  output logic           in_token_o,
  output logic           token_start_o,
  output logic [7:0]     token_number_o,
  output logic           last_o
);

  logic        in_valid_q;
  logic [7:0]  ch_q;
  logic        eol_q;
  logic        out_valid_q;
  char_class_e cls_q;
  tok_info_t   tok_q;
  logic        last_q;

  logic        advance;
  logic        step;
  cls_info_t   cls_info;
  tok_info_t   tok_info;
  quote_e      quote;

  // Move an item forward when the result register is empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ch_q  <= ch_i;
      eol_q <= end_of_line_i;
    end
  end

  sll_classify u_classify (
    .ch_i    (ch_q),
    .quote_i (quote),
    .info_o  (cls_info)
  );

  sll_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .eol_i   (eol_q),
    .info_i  (cls_info),
    .quote_o (quote),
    .tok_o   (tok_info)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      cls_q  <= cls_info.cls;
      tok_q  <= tok_info;
      last_q <= eol_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign char_class_o   = cls_q;
  assign in_token_o     = tok_q.in_token;
  assign token_start_o  = tok_q.token_start;
  assign token_number_o = tok_q.token_number;
  assign last_o         = last_q;

  // A byte that moves on always lands in the result register
  `SLL_ASSERT_NEXT(a_step_fills_out, step, out_valid_q)
  // The end of a line leaves no quote open
  `SLL_ASSERT_NEXT(a_eol_clears_quote, step && eol_q, quote == QuoteNone)
  // A starting token always has a nonzero number and belongs to a token
  `SLL_ASSERT_IMPL(a_start_numbered, out_valid_q && token_start_o, token_number_o != '0 && in_token_o)

endmodule

`default_nettype wire
